// ===== rtl/ccc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, sizes and codes of the centroid centering crop unit.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // Image geometry
  localparam int IN_SIDE_MAX  = 64;
  localparam int OUT_SIDE_MAX = 32;
  localparam int IDX_W        = $clog2(IN_SIDE_MAX);
  localparam int STORE_DEPTH  = IN_SIDE_MAX * IN_SIDE_MAX;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // Field widths
  localparam int PIXEL_W      = 8;
  localparam int ROW_W        = 5;
  localparam int IN_SIDE_W    = 7;
  localparam int OUT_SIDE_W   = 6;
  localparam int TARGET_W     = 7;

  // Accumulator and offset arithmetic
  localparam int SUM_W        = 27;
  localparam int WEIGHT_W     = 21;
  localparam int TERM_W       = IDX_W + PIXEL_W;
  localparam int NUM_W        = SUM_W + 1;
  localparam int DIVIDEND_W   = NUM_W + 1;
  localparam int DIVISOR_W    = WEIGHT_W + 1;
  localparam int OFF_W        = 8;
  localparam int POS_W        = OFF_W + 1;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;
  localparam logic [CFG_IDX_W-1:0] REG_IN_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd2;

  localparam logic [IN_SIDE_W-1:0]  IN_SIDE_RESET  = 7'd50;
  localparam logic [OUT_SIDE_W-1:0] OUT_SIDE_RESET = 6'd28;
  localparam logic [TARGET_W-1:0]   TARGET_RESET   = 7'd27;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Command kinds passed from front to back
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] CMD_LOAD      = 2'd0;
  localparam logic [KIND_W-1:0] CMD_LOAD_LAST = 2'd1;
  localparam logic [KIND_W-1:0] CMD_READ      = 2'd2;

  // Queue depths (powers of two)
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic               opcode;
    logic [PIXEL_W-1:0] pixel;
    logic               last_pixel;
    logic [ROW_W-1:0]   out_row;
    logic [ROW_W-1:0]   out_col;
  } req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    logic               source_valid;
  } res_t;

  typedef struct packed {
    logic [IN_SIDE_W-1:0]  in_side;
    logic [OUT_SIDE_W-1:0] out_side;
    logic [TARGET_W-1:0]   target_center_twice;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PIXEL_W-1:0] pixel;
    logic [ROW_W-1:0]   out_row;
    logic [ROW_W-1:0]   out_col;
  } cmd_t;

endpackage

// ===== rtl/ccc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ccc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccc_div
  import ccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      count;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // One trial subtraction per step
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  assign busy     = count != '0;
  assign quotient = quo;

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == CNT_W'(1));
      if (start && !busy) begin
        count <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/ccc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_front
// Accepts request items, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module ccc_front
  import ccc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  cmd_t                cq [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;
  cmd_t                cls;

  // Classify the incoming item
  always_comb begin
    cls.pixel   = request.pixel;
    cls.out_row = request.out_row;
    cls.out_col = request.out_col;
    unique case (request.opcode)
      OP_READ: cls.kind = CMD_READ;
      OP_LOAD: cls.kind = request.last_pixel ? CMD_LOAD_LAST : CMD_LOAD;
      default: cls.kind = CMD_LOAD;
    endcase
  end

  assign full      = count == CQ_CNT_W'(CQ_DEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = cq[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CQ_CNT_W'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      cq[wr_ptr] <= cls;
    end
  end

endmodule

// ===== rtl/ccc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_back
// Execution engine: stores and accumulates pixels, derives the centering
// offsets after the last pixel and serves cropped reads into a result queue.
// ----------------------------------------------------------------------------
module ccc_back
  import ccc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output res_t result,
  output logic empty,
  input  logic pop
);

  localparam logic [2:0] S_RUN   = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [IDX_W-1:0]       load_row;
  logic [IDX_W-1:0]       load_col;
  logic                   load_full;
  logic [SUM_W-1:0]       row_sum;
  logic [SUM_W-1:0]       col_sum;
  logic [WEIGHT_W-1:0]    weight;
  logic signed [OFF_W-1:0] row_offset;
  logic signed [OFF_W-1:0] col_offset;
  logic                   sel_col;
  logic [NUM_W-1:0]       prod;
  logic [NUM_W-1:0]       mag;
  logic                   neg;
  logic                   read_valid;

  logic [IN_SIDE_W-1:0]   side;
  logic [OUT_SIDE_W-1:0]  oside;
  logic                   is_load;
  logic                   is_last;
  logic                   is_read;
  logic                   load_go;
  logic                   rd_issue;
  logic                   in_range;
  logic                   store_we;
  logic                   col_wrap;
  logic                   row_wrap;
  logic [TERM_W-1:0]      row_term;
  logic [TERM_W-1:0]      col_term;
  logic [NUM_W-1:0]       twice_sum;
  logic signed [POS_W-1:0] src_row;
  logic signed [POS_W-1:0] src_col;
  logic                   src_ok;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [PIXEL_W-1:0]     rdata;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [DIVIDEND_W-1:0]  div_dividend;
  logic [DIVIDEND_W-1:0]  quo;
  logic signed [OFF_W-1:0] off_sat;

  res_t                   oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]    oq_wr;
  logic [OQ_PTR_W-1:0]    oq_rd;
  logic [OQ_CNT_W-1:0]    oq_count;
  logic                   oq_full;
  logic                   oq_push;
  logic                   oq_pop;
  res_t                   oq_item;

  // Effective sides, clamped to 1..max
  always_comb begin
    if (cfg.in_side == '0) begin
      side = IN_SIDE_W'(1);
    end else if (cfg.in_side > IN_SIDE_W'(IN_SIDE_MAX)) begin
      side = IN_SIDE_W'(IN_SIDE_MAX);
    end else begin
      side = cfg.in_side;
    end
    if (cfg.out_side == '0) begin
      oside = OUT_SIDE_W'(1);
    end else if (cfg.out_side > OUT_SIDE_W'(OUT_SIDE_MAX)) begin
      oside = OUT_SIDE_W'(OUT_SIDE_MAX);
    end else begin
      oside = cfg.out_side;
    end
  end

  // Command decode
  assign is_read  = cmd.kind == CMD_READ;
  assign is_last  = cmd.kind == CMD_LOAD_LAST;
  assign is_load  = (cmd.kind == CMD_LOAD) || is_last;
  assign load_go  = (state == S_RUN) && cmd_valid && is_load;
  assign rd_issue = (state == S_RUN) && cmd_valid && is_read && !oq_full;
  assign cmd_pop  = load_go || rd_issue;

  // Load position and weighted terms
  assign in_range = (IN_SIDE_W'(load_row) < side) && (IN_SIDE_W'(load_col) < side);
  assign store_we = load_go && !load_full && in_range;
  assign col_wrap = (IN_SIDE_W'(load_col) + IN_SIDE_W'(1)) >= side;
  assign row_wrap = (IN_SIDE_W'(load_row) + IN_SIDE_W'(1)) >= side;
  assign row_term = TERM_W'(load_row) * TERM_W'(cmd.pixel);
  assign col_term = TERM_W'(load_col) * TERM_W'(cmd.pixel);
  assign waddr    = {load_row, load_col};

  // Shifted source position of a read
  assign src_row = $signed({{(POS_W-ROW_W){1'b0}}, cmd.out_row})
                 + $signed({row_offset[OFF_W-1], row_offset});
  assign src_col = $signed({{(POS_W-ROW_W){1'b0}}, cmd.out_col})
                 + $signed({col_offset[OFF_W-1], col_offset});
  assign src_ok  = (OUT_SIDE_W'(cmd.out_row) < oside)
                && (OUT_SIDE_W'(cmd.out_col) < oside)
                && !src_row[POS_W-1] && !src_col[POS_W-1]
                && (src_row[POS_W-2:0] < (POS_W-1)'(side))
                && (src_col[POS_W-2:0] < (POS_W-1)'(side));
  assign raddr   = {src_row[IDX_W-1:0], src_col[IDX_W-1:0]};

  ccc_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(waddr),
    .wdata(cmd.pixel),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Offset divider: q = (|num| + w) / 2w
  assign twice_sum    = sel_col ? {col_sum, 1'b0} : {row_sum, 1'b0};
  assign div_start    = state == S_START;
  assign div_dividend = DIVIDEND_W'(mag) + DIVIDEND_W'(weight);

  ccc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor ({weight, 1'b0}),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(quo)
  );

  // Signed, saturated offset
  always_comb begin
    if (neg) begin
      if (quo > DIVIDEND_W'(128)) off_sat = -OFF_W'(128);
      else                        off_sat = OFF_W'(OFF_W'(0) - quo[OFF_W-1:0]);
    end else begin
      if (quo > DIVIDEND_W'(127)) off_sat = OFF_W'(127);
      else                        off_sat = quo[OFF_W-1:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (load_go && is_last) state_next = S_MUL;
        else if (rd_issue)      state_next = S_READ;
      end
      S_READ:  state_next = S_RUN;
      S_MUL:   state_next = (weight == '0) ? S_RUN : S_SUB;
      S_SUB:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_done) state_next = sel_col ? S_RUN : S_SUB;
      end
      default: state_next = S_RUN;
    endcase
  end

  // Control state and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RUN;
      load_row   <= '0;
      load_col   <= '0;
      load_full  <= 1'b0;
      row_sum    <= '0;
      col_sum    <= '0;
      weight     <= '0;
      row_offset <= '0;
      col_offset <= '0;
      sel_col    <= 1'b0;
    end else begin
      state <= state_next;
      if (store_we) begin
        row_sum <= row_sum + SUM_W'(row_term);
        col_sum <= col_sum + SUM_W'(col_term);
        weight  <= weight + WEIGHT_W'(cmd.pixel);
      end
      if (load_go) begin
        if (is_last) begin
          load_row  <= '0;
          load_col  <= '0;
          load_full <= 1'b0;
          sel_col   <= 1'b0;
        end else if (!load_full) begin
          if (col_wrap) begin
            load_col <= '0;
            if (row_wrap) load_full <= 1'b1;
            else          load_row  <= load_row + IDX_W'(1);
          end else begin
            load_col <= load_col + IDX_W'(1);
          end
        end
      end
      // Zero weight leaves both offsets at zero
      if (state == S_MUL && weight == '0) begin
        row_offset <= '0;
        col_offset <= '0;
      end
      if (state == S_DIV && div_done) begin
        if (sel_col) begin
          col_offset <= off_sat;
          row_sum    <= '0;
          col_sum    <= '0;
          weight     <= '0;
        end else begin
          row_offset <= off_sat;
          sel_col    <= 1'b1;
        end
      end
    end
  end

  // Offset datapath registers
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= NUM_W'(cfg.target_center_twice) * NUM_W'(weight);
    end
    if (state == S_SUB) begin
      neg <= twice_sum < prod;
      mag <= (twice_sum < prod) ? (prod - twice_sum) : (twice_sum - prod);
    end
    if (rd_issue) begin
      read_valid <= src_ok;
    end
  end

  // Result queue
  assign oq_full          = oq_count == OQ_CNT_W'(OQ_DEPTH);
  assign empty            = oq_count == '0;
  assign result           = oq[oq_rd];
  assign oq_push          = state == S_READ;
  assign oq_pop           = pop && !empty;
  assign oq_item.out_pixel    = read_valid ? rdata : '0;
  assign oq_item.source_valid = read_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) oq_wr <= oq_wr + OQ_PTR_W'(1);
      if (oq_pop)  oq_rd <= oq_rd + OQ_PTR_W'(1);
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + OQ_CNT_W'(1);
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - OQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= oq_item;
    end
  end

`ifndef SYNTHESIS
  // A read in flight always has a free slot waiting for it
  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> oq_count < OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue full while a read completes");

  // Divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside the divide step");

  // While the sequencer waits and no quotient is ready, the divider is running
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && !div_done |-> div_busy)
    else $error("divider idle during the divide step");

  // Every result item follows a store read issued the cycle before
  a_push_src: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> $past(rd_issue))
    else $error("result item without a preceding read");
`endif

endmodule

// ===== rtl/centroid_centering_crop_unit.sv =====
`timescale 1ns / 1ps
// Load items retire at one per cycle while the engine is in its run state; a read passes the run
// and read states (registered store read) and reaches the result ports through the result queue.
// The last pixel starts the offset computation, which runs the bit-serial divider twice (rows,
// then columns) unless the weight is zero; later items wait in the command queue.
// Reset (synchronous, active high) clears queues, sums, offsets and restores register defaults;
// the image store is not cleared.
// ----------------------------------------------------------------------------
// centroid_centering_crop_unit
// Loads a square image, centers its intensity centroid and serves crop reads.
// ----------------------------------------------------------------------------
module centroid_centering_crop_unit
  import ccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  req_t                  request,
  output logic                  empty,
  input  logic                  pop,
  output res_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_side             <= IN_SIDE_RESET;
      cfg.out_side            <= OUT_SIDE_RESET;
      cfg.target_center_twice <= TARGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_SIDE:  cfg.in_side             <= cfg_data[IN_SIDE_W-1:0];
        REG_OUT_SIDE: cfg.out_side            <= cfg_data[OUT_SIDE_W-1:0];
        REG_TARGET:   cfg.target_center_twice <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  ccc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  ccc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== tb/tb_centroid_centering_crop_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_centroid_centering_crop_unit
// Self-checking bench for the centroid centering crop unit. Images of many
// sizes are loaded and then cropped by read items. A tracker class keeps its
// own copy of the image store, the running sums and the offsets, and scores
// every read result in order. Sender gaps, receiver stalls, a long receiver
// hold-off and register changes between phases are all exercised.
// ----------------------------------------------------------------------------
module tb_centroid_centering_crop_unit;
  import ccc_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int SETTLE_CYCLES = 200;   // covers the offset divider and queued items
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1100;
  localparam int MAX_REPORTS = 10;
  localparam longint LIMIT_NS = 5_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored

  // Tracks image contents, centroid sums and offsets; holds the pixels due
  class crop_tracker;
    logic [PIXEL_W-1:0]    image_mem [STORE_DEPTH];
    bit                    written [STORE_DEPTH];
    int                    load_row;
    int                    load_col;
    bit                    load_full;
    bit [SUM_W-1:0]        row_sum;
    bit [SUM_W-1:0]        col_sum;
    bit [WEIGHT_W-1:0]     weight;
    int                    row_off;
    int                    col_off;
    logic [IN_SIDE_W-1:0]  in_side;
    logic [OUT_SIDE_W-1:0] out_side;
    logic [TARGET_W-1:0]   target;
    res_t                  pixel_due_q[$];
    int                    errors;

    function new();
      load_row = 0;
      load_col = 0;
      load_full = 1'b0;
      row_sum = '0;
      col_sum = '0;
      weight = '0;
      row_off = 0;
      col_off = 0;
      in_side = IN_SIDE_RESET;
      out_side = OUT_SIDE_RESET;
      target = TARGET_RESET;
      errors = 0;
    endfunction

    function int fit_side(int v, int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int in_side_eff();
      return fit_side(int'(in_side), IN_SIDE_MAX);
    endfunction

    function int out_side_eff();
      return fit_side(int'(out_side), OUT_SIDE_MAX);
    endfunction

    function int pending();
      return pixel_due_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_IN_SIDE:  in_side = d[IN_SIDE_W-1:0];
        REG_OUT_SIDE: out_side = d[OUT_SIDE_W-1:0];
        REG_TARGET:   target = d[TARGET_W-1:0];
        default: ;
      endcase
    endfunction

    // round((2*sum - t2*w) / (2*w)), ties away from zero, saturated
    function int shift_of(longint sum, longint w);
      longint num;
      longint mag;
      longint q;
      if (w == 0) return 0;
      num = 2 * sum - longint'(target) * w;
      mag = (num < 0) ? -num : num;
      q = (mag + w) / (2 * w);
      if (num < 0) q = -q;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      return int'(q);
    endfunction

    function void load_pixel(req_t r);
      int side;
      int addr;
      side = in_side_eff();
      if (!load_full) begin
        // positions beyond a shrunk side still advance but are not kept
        if (load_row < side && load_col < side) begin
          addr = load_row * IN_SIDE_MAX + load_col;
          image_mem[addr] = r.pixel;
          written[addr] = 1'b1;
          row_sum = row_sum + SUM_W'(load_row * int'(r.pixel));
          col_sum = col_sum + SUM_W'(load_col * int'(r.pixel));
          weight = weight + WEIGHT_W'(r.pixel);
        end
        if (load_col + 1 >= side) begin
          load_col = 0;
          if (load_row + 1 >= side) load_full = 1'b1;
          else load_row++;
        end else begin
          load_col++;
        end
      end
      // the closing pixel fixes the offsets and starts a fresh image
      if (r.last_pixel) begin
        row_off = shift_of(row_sum, weight);
        col_off = shift_of(col_sum, weight);
        load_row = 0;
        load_col = 0;
        load_full = 1'b0;
        row_sum = '0;
        col_sum = '0;
        weight = '0;
      end
    endfunction

    // Source position of a read; returns 1 when it lies inside both images
    function bit locate(req_t r, output int addr);
      int oside;
      int side;
      int sr;
      int sc;
      oside = out_side_eff();
      side = in_side_eff();
      sr = int'(r.out_row) + row_off;
      sc = int'(r.out_col) + col_off;
      addr = 0;
      if (int'(r.out_row) < oside && int'(r.out_col) < oside &&
          sr >= 0 && sc >= 0 && sr < side && sc < side) begin
        addr = sr * IN_SIDE_MAX + sc;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit touches_unwritten(req_t r);
      int addr;
      bit hit;
      hit = locate(r, addr);
      return hit && !written[addr];
    endfunction

    function void note_request(req_t r);
      res_t e;
      int addr;
      if (r.opcode == OP_LOAD) begin
        load_pixel(r);
      end else begin
        e = '0;
        if (locate(r, addr)) begin
          e.out_pixel = image_mem[addr];
          e.source_valid = 1'b1;
        end
        pixel_due_q.push_back(e);
      end
    endfunction

    function void check_pixel(res_t got);
      res_t e;
      if (pixel_due_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result: pixel %0d valid %0b", got.out_pixel, got.source_valid);
        errors++;
        return;
      end
      e = pixel_due_q.pop_front();
      if (got.out_pixel !== e.out_pixel || got.source_valid !== e.source_valid) begin
        if (errors < MAX_REPORTS)
          $display("mismatch: expected pixel %0d valid %0b, got pixel %0d valid %0b",
                   e.out_pixel, e.source_valid, got.out_pixel, got.source_valid);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  push;
  logic                  full;
  req_t                  request;
  logic                  empty;
  logic                  pop;
  res_t                  result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crop_tracker sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int items_sent = 0;

  centroid_centering_crop_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Offer one item, with random gaps ahead of it, and wait until it is taken
  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    request <= r;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_request(r);
    items_sent++;
  endtask

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  function automatic req_t read_item(int row, int col, bit lp);
    req_t r;
    r.opcode = OP_READ;
    r.pixel = PIXEL_W'($urandom);
    r.last_pixel = lp;
    r.out_row = ROW_W'(row);
    r.out_col = ROW_W'(col);
    return r;
  endfunction

  task automatic send_load(logic [PIXEL_W-1:0] px, bit lp);
    req_t r;
    r.opcode = OP_LOAD;
    r.pixel = px;
    r.last_pixel = lp;
    r.out_row = ROW_W'($urandom);
    r.out_col = ROW_W'($urandom);
    send_item(r);
  endtask

  // Reads that would hit a never-written store entry are dropped
  task automatic send_read(int row, int col, bit lp);
    req_t r;
    r = read_item(row, col, lp);
    if (!sb.touches_unwritten(r)) send_item(r);
  endtask

  task automatic send_random_read();
    req_t r;
    int oside;
    int row;
    int col;
    bit lp;
    bit found;
    lp = ($urandom_range(9) == 0);
    oside = sb.out_side_eff();
    found = 1'b0;
    for (int k = 0; k < 8 && !found; k++) begin
      row = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(oside - 1);
      col = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(oside - 1);
      r = read_item(row, col, lp);
      found = !sb.touches_unwritten(r);
    end
    // fall back to any position that stays on written data
    for (int rr = 0; rr < 32 && !found; rr++)
      for (int cc = 0; cc < 32 && !found; cc++) begin
        r = read_item(rr, cc, lp);
        found = !sb.touches_unwritten(r);
      end
    if (found) send_item(r);
  endtask

  // One image: complete for sides up to 12, else a random prefix; sometimes cut short or overfilled
  task automatic send_image();
    int side;
    int n;
    int extra;
    int k;
    bit blank;
    side = sb.in_side_eff();
    blank = ($urandom_range(9) == 0);
    n = (side > 12) ? $urandom_range(1, 120) : side * side;
    extra = 0;
    k = $urandom_range(9);
    if (k == 0) n = $urandom_range(1, n);
    else if (k == 1) extra = $urandom_range(1, 5);
    for (int i = 0; i < n + extra; i++) begin
      if ($urandom_range(29) == 0) send_random_read();
      send_load(blank ? '0 : rand_pixel(), i == n + extra - 1);
    end
  endtask

  // Wait for the block to go idle
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.set_reg(idx, d);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] in_v, logic [CFG_DATA_W-1:0] out_v,
                           logic [CFG_DATA_W-1:0] tgt_v);
    settle();
    write_reg(REG_IN_SIDE, in_v);
    write_reg(REG_OUT_SIDE, out_v);
    write_reg(REG_TARGET, tgt_v);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(int p);
    case (p)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Score each result taken from the block
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_pixel(result);
  end

  // Stimulus
  initial begin
    int start;
    int round;
    int nr;
    int k;
    logic [CFG_DATA_W-1:0] in_v;
    logic [CFG_DATA_W-1:0] out_v;
    logic [CFG_DATA_W-1:0] tgt_v;

    rst = 1'b1;
    push = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    set_phase(0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: short image, reads on, before and beside it
    send_load(8'd255, 1'b0);
    send_load(8'd0, 1'b0);
    send_load(8'd128, 1'b1);
    send_read(14, 13, 1'b0);
    send_read(14, 14, 1'b1);
    send_read(14, 15, 1'b0);
    send_read(0, 0, 1'b0);
    send_read(31, 31, 1'b0);

    // Smallest sides; loads past a full image are dropped
    configure(7'd0, 7'd0, 7'd0);
    send_load(8'd200, 1'b0);
    send_load(8'd99, 1'b0);
    send_load(8'd55, 1'b0);
    send_load(8'd7, 1'b1);
    send_read(0, 0, 1'b0);
    send_read(0, 1, 1'b0);
    send_read(1, 0, 1'b1);

    // Side shrinks while an image is half loaded
    configure(7'd3, 7'd32, 7'd2);
    send_load(8'd10, 1'b0);
    send_load(8'd20, 1'b0);
    configure(7'd2, 7'd32, 7'd2);
    send_load(8'd30, 1'b0);
    send_load(8'd40, 1'b0);
    send_load(8'd50, 1'b0);
    send_load(8'd60, 1'b1);
    send_read(0, 0, 1'b0);
    send_read(1, 1, 1'b0);
    send_read(31, 31, 1'b0);
    send_read(31, 0, 1'b0);

    // Random images and crops
    start = items_sent;
    round = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      k = (items_sent - start) * 4 / RANDOM_ITEMS;
      set_phase(k);
      if (round == 0) begin
        configure(7'd127, 7'd63, 7'd127);
      end else if (round == 1) begin
        configure(7'd64, 7'd1, 7'd126);
      end else if ($urandom_range(1) == 0) begin
        k = $urandom_range(9);
        if (k < 6) in_v = CFG_DATA_W'($urandom_range(1, 8));
        else if (k == 6) in_v = '0;
        else if (k == 7) in_v = '1;
        else if (k == 8) in_v = CFG_DATA_W'(IN_SIDE_MAX);
        else in_v = CFG_DATA_W'($urandom);
        out_v = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                         : CFG_DATA_W'($urandom_range(1, 32));
        tgt_v = ($urandom_range(1) == 0) ? CFG_DATA_W'($urandom_range(20))
                                         : CFG_DATA_W'($urandom);
        configure(in_v, out_v, tgt_v);
      end
      send_image();
      nr = $urandom_range(4, 30);
      // receiver backs off while reads keep coming, so the input stalls
      if (round % 9 == 2) begin
        hold_req = 1'b1;
        nr = 40;
      end
      for (int j = 0; j < nr; j++) send_random_read();
      round++;
    end

    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ccc_pkg.sv
rtl/ccc_ram.sv
rtl/ccc_div.sv
rtl/ccc_front.sv
rtl/ccc_back.sv
rtl/centroid_centering_crop_unit.sv
tb/tb_centroid_centering_crop_unit.sv
